[design/qslerp_pkg.sv]
package qslerp_pkg;

   // Fixed formats of the datapath
   localparam int ANG_BITS    = 30;  // Q.30 angles, sines and scales
   localparam int COMP_W      = 16;  // quaternion component, Q2.F
   localparam int WEIGHT_W    = 15;  // interpolation weight
   localparam int THR_W       = 15;  // linear threshold register
   localparam int C_W         = 31;  // cosine, root and angle magnitudes
   localparam int CRD_W       = 34;  // CORDIC x, y, z
   localparam int SCALE_W     = 33;  // scales in [-2.0, 2.0] Q.30
   localparam int ROOT_BITS   = 31;  // root bits, one stage each
   localparam int QUO_BITS    = 31;  // quotient bits, one stage each
   localparam int QUEUE_DEPTH = 4;

   // atan(2^-k) in Q.30, rounded to nearest
   localparam logic [30:0] ATAN_Q30 [32] = '{
      31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
      31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
      31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
      31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
      31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
   };

   // One classified request between front and back
   typedef struct packed {
      logic [3:0][COMP_W-1:0] a;      // start quaternion
      logic [3:0][COMP_W:0]   b;      // end quaternion, negated for the short arc
      logic [WEIGHT_W-1:0]    t;      // weight, saturated to 1.0
      logic                   slerp;  // spherical weights wanted
      logic [C_W-1:0]         c;      // cosine in Q.30, zero when linear
   } qslerp_item_type;

endpackage

[design/qslerp_front.sv]
module qslerp_front import qslerp_pkg::*; #(
   parameter int FRAC_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [3:0][COMP_W-1:0] req_a,
   input  logic [3:0][COMP_W-1:0] req_b,
   input  logic [WEIGHT_W-1:0]    req_weight,
   input  logic [THR_W-1:0]       threshold,
   input  logic                   q_ready,
   output logic                   q_push,
   output qslerp_item_type        q_item
);

   localparam int SH_R = (2 * FRAC_BITS >= ANG_BITS) ? 2 * FRAC_BITS - ANG_BITS : 0;
   localparam int SH_L = (2 * FRAC_BITS <  ANG_BITS) ? ANG_BITS - 2 * FRAC_BITS : 0;

   logic [2:0] valid_ff, valid_in;
   logic       adv;

   logic signed [31:0]     prod_ff [4];
   logic [3:0][COMP_W-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic [WEIGHT_W-1:0]    t1_ff, t2_ff;
   logic signed [33:0]     dot_ff, dot_in;
   logic signed [61:0]     lim_ff, lim_in;
   qslerp_item_type        item_ff, item_in;

   logic signed [33:0]     dabs;
   logic [63:0]            c_wide;
   logic [31:0]            one32;

   assign adv       = !valid_ff[2] || q_ready;
   assign req_ready = adv;
   assign q_push    = valid_ff[2] && q_ready;
   assign q_item    = item_ff;

   assign valid_in = {valid_ff[1], valid_ff[0], req_valid};

   // slerp iff |dot| + thr << F < 1.0 squared
   assign lim_in = (62'sd1 <<< (2 * FRAC_BITS)) - $signed(62'(threshold) << FRAC_BITS);

   always_comb begin
      dot_in = 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
   end

   always_comb begin
      one32   = 32'd1 << FRAC_BITS;
      dabs    = dot_ff[33] ? -dot_ff : dot_ff;
      item_in = '0;
      item_in.a     = a2_ff;
      item_in.slerp = 62'(dabs) < lim_ff;
      for (int k = 0; k < 4; k++) begin
         item_in.b[k] = dot_ff[33] ? 17'(-$signed(17'($signed(b2_ff[k]))))
                                   : 17'($signed(b2_ff[k]));
      end
      item_in.t = (32'(t2_ff) > one32) ? one32[WEIGHT_W-1:0] : t2_ff;
      c_wide    = (64'(dabs) >> SH_R) << SH_L;
      item_in.c = item_in.slerp ? c_wide[C_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff <= lim_in;
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= 32'($signed(req_a[k])) * 32'($signed(req_b[k]));
         end
         a1_ff   <= req_a;
         b1_ff   <= req_b;
         t1_ff   <= req_weight;
         dot_ff  <= dot_in;
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         t2_ff   <= t1_ff;
         item_ff <= item_in;
      end
   end

endmodule

[design/qslerp_queue.sv]
module qslerp_queue import qslerp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  qslerp_item_type push_item,
   output logic            push_ready,
   input  logic            pop,
   output logic            pop_valid,
   output qslerp_item_type pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   qslerp_item_type   mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[design/qslerp_sin.sv]
module qslerp_sin import qslerp_pkg::*; #(
   parameter int STEPS = 16
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [C_W-1:0]          angle,
   output logic signed [CRD_W-1:0] sine
);

   // rotation mode from x = 1.0, y = 0; gain left in, cancels in ratios
   logic signed [CRD_W-1:0] x_ff [STEPS];
   logic signed [CRD_W-1:0] y_ff [STEPS];
   logic signed [CRD_W-1:0] z_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [CRD_W-1:0] ATAN = CRD_W'(ATAN_Q30[i % 32]);
      logic signed [CRD_W-1:0] x_prev, y_prev, z_prev, x_in, y_in, z_in;
      if (i == 0) begin : g_first
         assign x_prev = CRD_W'(1) <<< ANG_BITS;
         assign y_prev = '0;
         assign z_prev = $signed(CRD_W'(angle));
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
      end
      always_comb begin
         if (!z_prev[CRD_W-1]) begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - ATAN;
         end else begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + ATAN;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   assign sine = y_ff[STEPS-1];

endmodule

[design/qslerp_div.sv]
module qslerp_div import qslerp_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [CRD_W-1:0]   num,
   input  logic signed [CRD_W-1:0]   den,
   output logic signed [SCALE_W-1:0] quo
);

   // (num << 30) / den toward zero, magnitude clamped to 2.0 in Q.30
   localparam int REM_W = 32 + ANG_BITS;

   logic [REM_W-1:0]    rem_ff [QUO_BITS+1];
   logic [31:0]         den_ff [QUO_BITS+1];
   logic [QUO_BITS-1:0] q_ff   [QUO_BITS+1];
   logic                neg_ff [QUO_BITS+1];
   logic                over_ff [QUO_BITS+1];
   logic signed [SCALE_W-1:0] quo_ff;

   logic signed [CRD_W-1:0] num_abs;
   logic [SCALE_W-1:0]      mag;

   assign num_abs = num[CRD_W-1] ? -num : num;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= REM_W'(num_abs) << ANG_BITS;
         den_ff[0]  <= den[31:0];
         q_ff[0]    <= '0;
         neg_ff[0]  <= num[CRD_W-1];
         over_ff[0] <= CRD_W'(num_abs) >= {1'b0, den[31:0], 1'b0};
      end
   end

   for (genvar j = 1; j <= QUO_BITS; j++) begin : g_bit
      localparam int B = QUO_BITS - j;
      logic [REM_W-1:0] trial;
      logic             take;
      assign trial = REM_W'(den_ff[j-1]) << B;
      assign take  = rem_ff[j-1] >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= take ? rem_ff[j-1] - trial : rem_ff[j-1];
            q_ff[j]    <= q_ff[j-1] | (take ? QUO_BITS'(1) << B : '0);
            den_ff[j]  <= den_ff[j-1];
            neg_ff[j]  <= neg_ff[j-1];
            over_ff[j] <= over_ff[j-1];
         end
      end
   end

   assign mag = over_ff[QUO_BITS] ? SCALE_W'(1) << 31 : SCALE_W'(q_ff[QUO_BITS]);

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= neg_ff[QUO_BITS] ? -$signed(mag) : $signed(mag);
      end
   end

   assign quo = quo_ff;

endmodule

[design/qslerp_back.sv]
module qslerp_back import qslerp_pkg::*; #(
   parameter int FRAC_BITS    = 14,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  qslerp_item_type        q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0][COMP_W-1:0] rsp_out
);

   localparam int CS      = CORDIC_STEPS;
   localparam int UP      = ANG_BITS - FRAC_BITS;
   localparam int S_ROOT  = 1 + ROOT_BITS;
   localparam int S_W     = S_ROOT + CS + 1;
   localparam int S_TH    = S_W + 1;
   localparam int S_SIN   = S_TH + CS;
   localparam int S_DIV   = S_SIN + QUO_BITS + 2;
   localparam int S_OUT   = S_DIV + 2;
   localparam int N_W     = 2 * ANG_BITS + 1;
   localparam int PA_W    = SCALE_W + COMP_W;
   localparam int PB_W    = SCALE_W + COMP_W + 1;
   localparam int SUM_W   = PB_W + 1;

   logic              en;
   logic [S_OUT:0]    valid_ff;
   qslerp_item_type   item_ff [S_DIV+1];
   qslerp_item_type   sin_item;

   logic [2*C_W-1:0]  sq_ff;
   logic [N_W-1:0]    n_ff;
   logic [N_W-1:0]    rem_ff  [ROOT_BITS];
   logic [C_W-1:0]    root_ff [ROOT_BITS];

   logic signed [CRD_W-1:0] vx_ff [CS];
   logic signed [CRD_W-1:0] vy_ff [CS];
   logic signed [CRD_W-1:0] vz_ff [CS];

   logic [C_W-1:0]    w_ff, wd_ff, th0_ff, th1_ff;
   logic [31:0]       omt;
   logic [63:0]       th0_wide, th1_wide;

   logic signed [CRD_W-1:0]   sw, sa, sb;
   logic signed [SCALE_W-1:0] quo0, quo1, lin0, lin1, s0, s1;

   logic signed [PA_W-1:0] pa_ff [4];
   logic signed [PB_W-1:0] pb_ff [4];
   logic [3:0][COMP_W-1:0] out_ff;

   assign en        = !valid_ff[S_OUT] || rsp_ready;
   assign q_pop     = en && q_valid;
   assign rsp_valid = valid_ff[S_OUT];
   assign rsp_out   = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[S_OUT-1:0], q_valid};
      end
   end

   // request carried alongside; the slerp flag drops if sin(w) is not positive
   always_comb begin
      sin_item       = item_ff[S_SIN];
      sin_item.slerp = item_ff[S_SIN].slerp && (sw > 0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff[0] <= q_item;
         for (int j = 1; j <= S_DIV; j++) begin
            if (j == S_SIN + 1) begin
               item_ff[j] <= sin_item;
            end else begin
               item_ff[j] <= item_ff[j-1];
            end
         end
      end
   end

   // s = isqrt(1.0^2 - c^2), one root bit a stage
   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= (2*C_W)'(q_item.c) * (2*C_W)'(q_item.c);
         n_ff  <= N_W'((2*C_W)'(1) << (2 * ANG_BITS)) - N_W'(sq_ff);
      end
   end

   for (genvar m = 0; m < ROOT_BITS; m++) begin : g_root
      localparam int B = ROOT_BITS - 1 - m;
      logic [N_W-1:0] rem_prev;
      logic [C_W-1:0] root_prev;
      logic [N_W:0]   trial;
      logic           take;
      if (m == 0) begin : g_first
         assign rem_prev  = n_ff;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[m-1];
         assign root_prev = root_ff[m-1];
      end
      assign trial = ((N_W+1)'(root_prev) << (B + 1)) + ((N_W+1)'(1) << (2 * B));
      assign take  = {1'b0, rem_prev} >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[m]  <= take ? rem_prev - trial[N_W-1:0] : rem_prev;
            root_ff[m] <= root_prev | (take ? C_W'(1) << B : '0);
         end
      end
   end

   // w = atan2(s, c), vectoring
   for (genvar i = 0; i < CS; i++) begin : g_vec
      localparam logic signed [CRD_W-1:0] ATAN = CRD_W'(ATAN_Q30[i % 32]);
      logic signed [CRD_W-1:0] x_prev, y_prev, z_prev, x_in, y_in, z_in;
      if (i == 0) begin : g_first
         assign x_prev = $signed(CRD_W'(item_ff[S_ROOT].c));
         assign y_prev = $signed(CRD_W'(root_ff[ROOT_BITS-1]));
         assign z_prev = '0;
      end else begin : g_next
         assign x_prev = vx_ff[i-1];
         assign y_prev = vy_ff[i-1];
         assign z_prev = vz_ff[i-1];
      end
      always_comb begin
         if (y_prev > 0) begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + ATAN;
         end else begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - ATAN;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            vx_ff[i] <= x_in;
            vy_ff[i] <= y_in;
            vz_ff[i] <= z_in;
         end
      end
   end

   // clamp w, then the two partial angles
   assign omt      = (32'd1 << FRAC_BITS) - 32'(item_ff[S_W].t);
   assign th0_wide = (64'(w_ff) * 64'(omt)) >> FRAC_BITS;
   assign th1_wide = (64'(w_ff) * 64'(item_ff[S_W].t)) >> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff   <= vz_ff[CS-1][CRD_W-1] ? '0 : vz_ff[CS-1][C_W-1:0];
         wd_ff  <= w_ff;
         th0_ff <= th0_wide[C_W-1:0];
         th1_ff <= th1_wide[C_W-1:0];
      end
   end

   qslerp_sin #(.STEPS(CS)) u_sin_w (
      .clock (clock), .en (en), .angle (wd_ff),  .sine (sw)
   );
   qslerp_sin #(.STEPS(CS)) u_sin_a (
      .clock (clock), .en (en), .angle (th0_ff), .sine (sa)
   );
   qslerp_sin #(.STEPS(CS)) u_sin_b (
      .clock (clock), .en (en), .angle (th1_ff), .sine (sb)
   );

   qslerp_div u_div_a (.clock (clock), .en (en), .num (sa), .den (sw), .quo (quo0));
   qslerp_div u_div_b (.clock (clock), .en (en), .num (sb), .den (sw), .quo (quo1));

   // scale select and blend
   always_comb begin
      lin0 = $signed(((SCALE_W)'(1) << FRAC_BITS) - SCALE_W'(item_ff[S_DIV].t)) <<< UP;
      lin1 = $signed(SCALE_W'(item_ff[S_DIV].t)) <<< UP;
      s0   = item_ff[S_DIV].slerp ? quo0 : lin0;
      s1   = item_ff[S_DIV].slerp ? quo1 : lin1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            pa_ff[k] <= PA_W'(s0) * PA_W'($signed(item_ff[S_DIV].a[k]));
            pb_ff[k] <= PB_W'(s1) * PB_W'($signed(item_ff[S_DIV].b[k]));
         end
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_out
      logic signed [SUM_W-1:0] sum, rnd;
      logic [COMP_W-1:0]       sat;
      always_comb begin
         sum = SUM_W'(pa_ff[k]) + SUM_W'(pb_ff[k]) + (SUM_W'(1) <<< (ANG_BITS - 1));
         rnd = sum >>> ANG_BITS;
         if (rnd > SUM_W'(32767)) begin
            sat = 16'h7fff;
         end else if (rnd < -SUM_W'(32768)) begin
            sat = 16'h8000;
         end else begin
            sat = rnd[COMP_W-1:0];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            out_ff[k] <= sat;
         end
      end
   end

endmodule

[design/quaternion_slerp.sv]
// Throughput: one request per cycle while rsp_ready keeps results moving; the back
//   pipeline advances as one unit and halts only while a result sits unclaimed
//   in the output register.
// Reset: synchronous, active high; empties front, queue and back pipeline and
//   clears linear_threshold to zero.
module quaternion_slerp import qslerp_pkg::*; #(
   parameter int FRAC_BITS    = 14,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // threshold register write
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [THR_W-1:0]         csr_linear_threshold,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [COMP_W-1:0] req_a_x,
   input  logic signed [COMP_W-1:0] req_a_y,
   input  logic signed [COMP_W-1:0] req_a_z,
   input  logic signed [COMP_W-1:0] req_a_w,
   input  logic signed [COMP_W-1:0] req_b_x,
   input  logic signed [COMP_W-1:0] req_b_y,
   input  logic signed [COMP_W-1:0] req_b_z,
   input  logic signed [COMP_W-1:0] req_b_w,
   input  logic [WEIGHT_W-1:0]      req_weight,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [COMP_W-1:0] rsp_out_x,
   output logic signed [COMP_W-1:0] rsp_out_y,
   output logic signed [COMP_W-1:0] rsp_out_z,
   output logic signed [COMP_W-1:0] rsp_out_w
);

   // Front: registers the request, forms a.b over two stages, then folds to
   //   the short arc, saturates t and decides slerp against the threshold.
   // Queue: four entries, so the front keeps taking requests while the back
   //   is held, until the queue is full.
   // Back: cos -> sin by a bit-serial square root, angle by a vectoring
   //   CORDIC, three rotating CORDICs for sin w, sin((1-t)w), sin(tw), two
   //   one-bit-a-stage dividers for the ratios, then blend, round and clip.

   logic [THR_W-1:0]       thr_ff, thr_in;
   logic [3:0][COMP_W-1:0] req_a, req_b, out_q;

   logic            q_push, q_push_ready, q_pop, q_pop_valid;
   qslerp_item_type q_push_item, q_pop_item;

   assign csr_ready = 1'b1;
   assign thr_in    = (csr_valid && csr_ready) ? csr_linear_threshold : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign req_a = {req_a_w, req_a_z, req_a_y, req_a_x};
   assign req_b = {req_b_w, req_b_z, req_b_y, req_b_x};

   qslerp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_a      (req_a),
      .req_b      (req_b),
      .req_weight (req_weight),
      .threshold  (thr_ff),
      .q_ready    (q_push_ready),
      .q_push     (q_push),
      .q_item     (q_push_item)
   );

   qslerp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .push_ready (q_push_ready),
      .pop        (q_pop),
      .pop_valid  (q_pop_valid),
      .pop_item   (q_pop_item)
   );

   qslerp_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_pop_valid),
      .q_item    (q_pop_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_out   (out_q)
   );

   assign rsp_out_x = out_q[0];
   assign rsp_out_y = out_q[1];
   assign rsp_out_z = out_q[2];
   assign rsp_out_w = out_q[3];

endmodule

[design/qslerp_check.sv]
module qslerp_check import qslerp_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     csr_valid,
   input logic                     csr_ready,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [COMP_W-1:0] rsp_out_x,
   input logic signed [COMP_W-1:0] rsp_out_y,
   input logic signed [COMP_W-1:0] rsp_out_z,
   input logic signed [COMP_W-1:0] rsp_out_w
);

   logic [15:0] pending_ff, pending_in;

   assign pending_in = pending_ff + 16'(req_valid && req_ready) - 16'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a result only for a request taken earlier
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result without a pending request");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("threshold write stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
         && $stable(rsp_out_z) && $stable(rsp_out_w))
      else $error("stalled result changed");

endmodule

bind quaternion_slerp qslerp_check u_check (
   .clock     (clock),
   .reset     (reset),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_out_x (rsp_out_x),
   .rsp_out_y (rsp_out_y),
   .rsp_out_z (rsp_out_z),
   .rsp_out_w (rsp_out_w)
);
